/* sv/htcs_pkg.sv */
// shared constants and a saturating-increment helper for the trigram count smoother
package htcs_pkg;
    localparam int STATE_COUNT = 4;
    localparam int OBS_COUNT   = 8192;
    localparam int COUNT_WIDTH = 32;
    localparam int TAG_W       = 2;
    localparam int OBS_W       = 13;
    localparam int SQ          = STATE_COUNT * STATE_COUNT;
    localparam int ROW_START   = 0;
    localparam int ROW_PAIR    = 1;
    localparam int ROW_TRIPLE  = ROW_PAIR + STATE_COUNT;
    localparam int ROW_EMIT    = ROW_TRIPLE + SQ;
    localparam int ROW_PEMIT   = ROW_EMIT + STATE_COUNT;
    localparam int ROW_ALL     = ROW_PEMIT + SQ;
    localparam int ROW_W       = $clog2(ROW_ALL);
    localparam int TRIP_DEPTH  = SQ * STATE_COUNT;
    localparam int TRIP_AW     = $clog2(TRIP_DEPTH);
    localparam int EMIT_DEPTH  = STATE_COUNT * OBS_COUNT;
    localparam int PEMIT_DEPTH = SQ * OBS_COUNT;
    localparam int EMIT_AW     = $clog2(EMIT_DEPTH);
    localparam int PEMIT_AW    = $clog2(PEMIT_DEPTH);
    localparam int CLEAR_W     = PEMIT_AW + 1;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int LOG_FRAC    = 20;

    localparam logic [2:0] SEL_START = 3'd0;
    localparam logic [2:0] SEL_PAIR  = 3'd1;
    localparam logic [2:0] SEL_TRIP  = 3'd2;
    localparam logic [2:0] SEL_EMIT  = 3'd3;
    localparam logic [2:0] SEL_PEMIT = 3'd4;

    localparam logic [0:0] REG_ADD = 1'b0;
    localparam logic [0:0] REG_OBS = 1'b1;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        sat_inc = (&v) ? v : v + 1'b1;
    endfunction
endpackage

/* sv/hmm_trigram_count_smoother_core.sv */
// top level: count tables, token sequencer and query log unit
//
// Channels: an input request (i_valid/o_ready) carries either a token
// (i_func 0) or a query (i_func 1). A token yields no result; a query yields
// one result on o_valid/i_ready with entry_count, row_total, neg_log_prob and
// bad_query. Configuration writes via i_cfg_we/i_cfg_addr/i_cfg_data.
// One request at a time: a token passes accept, read of the counter
// memories, then write of the affected counters and row totals, and o_ready
// is back once the write is done. A query passes memory read, two logarithms
// through one shared squaring multiplier at one fraction bit per cycle, then
// the ln2 scaling; a bad query skips the logarithms and the scaling.
// After reset the block sweeps all count memories clear, one entry per
// cycle, while o_ready stays low.
// The result sits in an output register; while the receiver stalls it is
// held and no new request is taken until it is taken.
module hmm_trigram_count_smoother_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [13:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic        i_sentence_start,
    input  logic [1:0]  i_state_tag,
    input  logic [12:0] i_observation,
    input  logic        i_obs_known,
    input  logic [2:0]  i_table_select,
    input  logic [3:0]  i_row_index,
    input  logic [12:0] i_column_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_entry_count,
    output logic [31:0] o_row_total,
    output logic [15:0] o_neg_log_prob,
    output logic        o_bad_query
);
    import htcs_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_TRD, S_TWR, S_QRD, S_QLAT,
        S_ARG, S_NORM, S_SQ, S_LMUL, S_OUT
    } t_state;

    t_state r_state;
    logic [CLEAR_W-1:0] r_clr;

    logic [7:0]  r_add;
    logic [13:0] r_obs_use;

    logic [1:0] r_pos, r_prev, r_older;

    logic [COUNT_WIDTH-1:0] r_start [STATE_COUNT];
    logic [COUNT_WIDTH-1:0] r_pair [SQ];
    logic [COUNT_WIDTH-1:0] r_tot_start;
    logic [COUNT_WIDTH-1:0] r_tot_pair [STATE_COUNT];
    logic [COUNT_WIDTH-1:0] r_tot_trip [SQ];
    logic [COUNT_WIDTH-1:0] r_tot_emit [STATE_COUNT];
    logic [COUNT_WIDTH-1:0] r_tot_pemit [SQ];
    logic [COUNT_WIDTH-1:0] m_trip [TRIP_DEPTH];
    logic [COUNT_WIDTH-1:0] m_emit [EMIT_DEPTH];
    logic [COUNT_WIDTH-1:0] m_pemit [PEMIT_DEPTH];

    logic [COUNT_WIDTH-1:0] r_trip_q, r_emit_q, r_pemit_q;
    logic [TRIP_AW-1:0]  r_ta;
    logic [EMIT_AW-1:0]  r_ea;
    logic [PEMIT_AW-1:0] r_pa;

    // latched request
    logic [1:0] r_tag, r_p, r_q;
    logic       r_usable;
    logic [2:0] r_sel;
    logic [3:0] r_row;
    logic [12:0] r_col;

    // query arithmetic
    logic [COUNT_WIDTH-1:0] r_cnt, r_tot_q;
    logic        r_bad;
    logic [41:0] r_num, r_den;
    logic        r_which;
    logic [30:0] r_m;
    logic [4:0]  r_it;
    logic [25:0] r_lg, r_lga;
    logic [57:0] r_prod;

    logic [13:0] olen;
    assign olen = (r_obs_use == 14'd0) ? 14'd1 :
                  (r_obs_use > 14'(OBS_COUNT)) ? 14'(OBS_COUNT) : r_obs_use;

    logic [13:0] row_len;
    assign row_len = (r_sel == SEL_EMIT || r_sel == SEL_PEMIT) ? olen : 14'(STATE_COUNT);

    // leading-one of current log operand
    logic [41:0] lx;
    logic [5:0]  lz;
    always_comb begin
        lx = r_which ? r_num : r_den;
        lz = '0;
        for (int k = 0; k < 42; k++) begin
            if (lx[k]) lz = 6'(k);
        end
    end

    logic [61:0] sqr;
    assign sqr = 62'(r_m) * 62'(r_m);
    logic [31:0] msq;
    assign msq = 32'(sqr >> 30);

    logic [25:0] n_lg;
    assign n_lg = msq[31] ? (r_lg | (26'd1 << (5'd19 - r_it))) : r_lg;

    // r_lg holds the log of the denominator, r_lga that of the numerator
    logic [25:0] diff;
    assign diff = (r_lg > r_lga) ? r_lg - r_lga : 26'd0;
    logic [57:0] rnd;
    assign rnd = (r_prod + (58'd1 << 41)) >> 42;

    assign o_ready = (r_state == S_IDLE) && !o_valid;

    logic [3:0] prow;
    assign prow = {r_prev, i_state_tag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_add   <= 8'd1;
            r_obs_use <= 14'd4577;
            r_pos <= '0; r_prev <= '0; r_older <= '0;
            o_valid <= 1'b0;
            r_tot_start <= '0;
            for (int k = 0; k < STATE_COUNT; k++) r_start[k] <= '0;
            for (int k = 0; k < SQ; k++) r_pair[k] <= '0;
            for (int k = 0; k < STATE_COUNT; k++) r_tot_pair[k] <= '0;
            for (int k = 0; k < SQ; k++) r_tot_trip[k] <= '0;
            for (int k = 0; k < STATE_COUNT; k++) r_tot_emit[k] <= '0;
            for (int k = 0; k < SQ; k++) r_tot_pemit[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ADD: r_add <= i_cfg_data[7:0];
                    default: r_obs_use <= i_cfg_data;
                endcase
            end
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    if (r_clr[PEMIT_AW]) r_state <= S_IDLE;
                    r_clr <= r_clr + CLEAR_W'(1);
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_tag <= i_state_tag;
                        r_usable <= i_obs_known && ({1'b0, i_observation} < olen);
                        r_q <= i_sentence_start ? 2'd0 : r_pos;
                        r_p <= r_prev;
                        r_sel <= i_table_select;
                        r_row <= i_row_index;
                        r_col <= i_column_index;
                        if (i_func == 1'b0) begin
                            r_ta <= {r_older, r_prev, i_state_tag};
                            r_ea <= {i_state_tag, i_observation};
                            r_pa <= {prow, i_observation};
                            r_state <= S_TRD;
                        end else begin
                            r_ta <= {i_row_index, i_column_index[1:0]};
                            r_ea <= {i_row_index[1:0], i_column_index};
                            r_pa <= {i_row_index, i_column_index};
                            r_state <= S_QRD;
                        end
                    end
                end
                S_TRD: r_state <= S_TWR;
                S_TWR: begin
                    if (r_q == 2'd0) begin
                        r_start[r_tag] <= sat_inc(r_start[r_tag]);
                        r_tot_start <= sat_inc(r_tot_start);
                    end
                    if (r_usable) begin
                        r_tot_emit[r_tag] <= sat_inc(r_tot_emit[r_tag]);
                    end
                    if (r_q >= 2'd1) begin
                        r_pair[{r_p, r_tag}] <= sat_inc(r_pair[{r_p, r_tag}]);
                        r_tot_pair[r_p] <= sat_inc(r_tot_pair[r_p]);
                        if (r_usable)
                            r_tot_pemit[{r_p, r_tag}] <= sat_inc(r_tot_pemit[{r_p, r_tag}]);
                    end
                    if (r_q >= 2'd2) begin
                        r_tot_trip[{r_older, r_p}] <= sat_inc(r_tot_trip[{r_older, r_p}]);
                    end
                    r_older <= r_p;
                    r_prev <= r_tag;
                    r_pos <= (r_q < 2'd2) ? r_q + 2'd1 : 2'd2;
                    r_state <= S_IDLE;
                end
                S_QRD: r_state <= S_QLAT;
                S_QLAT: begin
                    case (r_sel)
                        SEL_START: begin
                            r_bad <= (r_row != 4'd0) || (r_col >= 13'(STATE_COUNT));
                            r_cnt <= r_start[r_col[1:0]];
                            r_tot_q <= r_tot_start;
                        end
                        SEL_PAIR: begin
                            r_bad <= (r_row >= 4'(STATE_COUNT)) ||
                                     (r_col >= 13'(STATE_COUNT));
                            r_cnt <= r_pair[{r_row[1:0], r_col[1:0]}];
                            r_tot_q <= r_tot_pair[r_row[1:0]];
                        end
                        SEL_TRIP: begin
                            r_bad <= (r_col >= 13'(STATE_COUNT));
                            r_cnt <= r_trip_q;
                            r_tot_q <= r_tot_trip[r_row];
                        end
                        SEL_EMIT: begin
                            r_bad <= (r_row >= 4'(STATE_COUNT)) || ({1'b0, r_col} >= olen);
                            r_cnt <= r_emit_q;
                            r_tot_q <= r_tot_emit[r_row[1:0]];
                        end
                        SEL_PEMIT: begin
                            r_bad <= ({1'b0, r_col} >= olen);
                            r_cnt <= r_pemit_q;
                            r_tot_q <= r_tot_pemit[r_row];
                        end
                        default: begin
                            r_bad <= 1'b1;
                            r_cnt <= '0;
                            r_tot_q <= '0;
                        end
                    endcase
                    r_state <= S_ARG;
                end
                S_ARG: begin
                    if (r_bad) begin
                        r_state <= S_OUT;
                    end else begin
                        r_num <= 42'(r_cnt) + 42'(r_add);
                        r_den <= 42'(r_tot_q) + 42'(22'(r_add) * 22'(row_len));
                        r_which <= 1'b1;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    r_m <= (lz >= 6'd30) ? 31'(lx >> (lz - 6'd30))
                                         : 31'(lx << (6'd30 - lz));
                    r_lg <= 26'(lz) << LOG_FRAC;
                    r_it <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_m <= msq[31] ? msq[31:1] : msq[30:0];
                    r_lg <= n_lg;
                    r_it <= r_it + 5'd1;
                    if (r_it == 5'd19) begin
                        if (r_which) begin
                            r_lga <= n_lg;
                            r_which <= 1'b0;
                            r_state <= S_NORM;
                        end else begin
                            r_state <= S_LMUL;
                        end
                    end
                end
                S_LMUL: begin
                    r_prod <= 58'(diff) * 58'(LN2_Q32);
                    r_state <= S_OUT;
                end
                default: begin
                    o_valid <= 1'b1;
                    o_bad_query <= r_bad;
                    o_entry_count <= r_bad ? '0 : r_cnt;
                    o_row_total <= r_bad ? '0 : r_tot_q;
                    o_neg_log_prob <= r_bad ? 16'd0 :
                                      (r_num == 42'd0) ? 16'hFFFF :
                                      (rnd > 58'd65535) ? 16'hFFFF : 16'(rnd);
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            m_pemit[r_clr[PEMIT_AW-1:0]] <= '0;
            m_emit[r_clr[EMIT_AW-1:0]] <= '0;
            m_trip[r_clr[TRIP_AW-1:0]] <= '0;
        end else if (r_state == S_TWR) begin
            if (r_usable) begin
                m_emit[r_ea] <= sat_inc(r_emit_q);
                if (r_q >= 2'd1) m_pemit[r_pa] <= sat_inc(r_pemit_q);
            end
            if (r_q >= 2'd2) m_trip[r_ta] <= sat_inc(r_trip_q);
        end
        r_trip_q <= m_trip[r_ta];
        r_emit_q <= m_emit[r_ea];
        r_pemit_q <= m_pemit[r_pa];
    end
endmodule
